>>> rtl/lsf_pkg.sv
// Shared types and constants for the logical shift with flags block.
package lsf_pkg;

    // Operand size codes from instruction bits 7..6.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_MEM  = 2'd3;

    // Direction codes carried on the op input.
    localparam logic OP_LSR = 1'b0;
    localparam logic OP_LSL = 1'b1;

    // Field positions inside the instruction word.
    localparam int CNT_HI   = 11;
    localparam int CNT_LO   = 9;
    localparam int SIZE_HI  = 7;
    localparam int SIZE_LO  = 6;
    localparam int IR_BIT   = 5;

    // Immediate count of zero encodes a shift by eight.
    localparam logic [5:0] IMM_ZERO_COUNT = 6'd8;

    typedef struct packed {
        logic x;
        logic n;
        logic z;
        logic v;
        logic c;
        logic mem_form;
    } flags_t;

endpackage

>>> rtl/logical_shift_with_flags.sv
// Top level of the register-form logical shift with condition codes.
//
//  Channel   Handshake          Word carried
//  -------   ----------------   ---------------------------------------------
//  command   start, busy        op, instr_word, dest_value, count_reg_value, x_in
//  result    done (one cycle)   new_value, flag_x/n/z/v/c, not_register_form
//
// A word is taken at each rising edge with start high and busy low. Busy is
// always low, so a new word may be issued in every cycle. Each word yields
// exactly one result. The word passes through the input register, then
// through the shifter into the result register, whose valid bit drives done.
// Reset clears only the two valid bits; the payload registers are not reset.
// The receiver cannot stall, so each result is presented for one cycle only.
module logical_shift_with_flags (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [15:0] instr_word,
    input  logic [31:0] dest_value,
    input  logic [31:0] count_reg_value,
    input  logic        x_in,
    output logic        done,
    output logic [31:0] new_value,
    output logic        flag_x,
    output logic        flag_n,
    output logic        flag_z,
    output logic        flag_v,
    output logic        flag_c,
    output logic        not_register_form
);
    import lsf_pkg::*;

    // Input register stage.
    logic        in_valid_reg;
    logic        op_reg;
    logic [15:0] instr_reg;
    logic [31:0] dest_reg;
    logic [31:0] count_reg;
    logic        x_in_reg;

    // Result register stage.
    logic        out_valid_reg;
    logic [31:0] value_reg;
    flags_t      flags_reg;

    logic [31:0] value_next;
    flags_t      flags_next;
    logic        accept;

    // The pipeline never backs up, so the command side is always open.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= accept;
            out_valid_reg <= in_valid_reg;
        end
    end

    // Each payload register loads only when a valid word moves into it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            instr_reg <= instr_word;
            dest_reg  <= dest_value;
            count_reg <= count_reg_value;
            x_in_reg  <= x_in;
        end
        if (in_valid_reg)
        begin
            value_reg <= value_next;
            flags_reg <= flags_next;
        end
    end

    // Shifter and flag generation sit between the two register stages.
    lsf_core u_core (
        .op              (op_reg),
        .instr_word      (instr_reg),
        .dest_value      (dest_reg),
        .count_reg_value (count_reg),
        .x_in            (x_in_reg),
        .new_value       (value_next),
        .flags           (flags_next)
    );

    assign done              = out_valid_reg;
    assign new_value         = value_reg;
    assign flag_x            = flags_reg.x;
    assign flag_n            = flags_reg.n;
    assign flag_z            = flags_reg.z;
    assign flag_v            = flags_reg.v;
    assign flag_c            = flags_reg.c;
    assign not_register_form = flags_reg.mem_form;

endmodule

>>> rtl/lsf_core.sv
// Combinational shifter and condition code logic for one instruction.
module lsf_core (
    input  logic            op,
    input  logic [15:0]     instr_word,
    input  logic [31:0]     dest_value,
    input  logic [31:0]     count_reg_value,
    input  logic            x_in,
    output logic [31:0]     new_value,
    output lsf_pkg::flags_t flags
);
    import lsf_pkg::*;

    logic [1:0]  size;
    logic [2:0]  imm;
    logic [5:0]  cnt;
    logic [31:0] mask;
    logic [4:0]  msb;
    logic [5:0]  wbit;
    logic [31:0] v;
    logic [63:0] lsh;
    logic [63:0] rsh;
    logic [31:0] r;
    logic        c;
    logic        x;

    assign size = instr_word[SIZE_HI:SIZE_LO];
    assign imm  = instr_word[CNT_HI:CNT_LO];

    always_comb
    begin
        if (instr_word[IR_BIT])
        begin
            cnt = count_reg_value[5:0];
        end
        else if (imm == 3'd0)
        begin
            cnt = IMM_ZERO_COUNT;
        end
        else
        begin
            cnt = {3'b000, imm};
        end
    end

    always_comb
    begin
        unique case (size)
            SIZE_BYTE:
            begin
                mask = 32'h0000_00ff;
                msb  = 5'd7;
                wbit = 6'd8;
            end
            SIZE_WORD:
            begin
                mask = 32'h0000_ffff;
                msb  = 5'd15;
                wbit = 6'd16;
            end
            default:
            begin
                mask = 32'hffff_ffff;
                msb  = 5'd31;
                wbit = 6'd32;
            end
        endcase
    end

    assign v   = dest_value & mask;
    // Bit w of the left result and bit 31 of the right result hold the last bit out.
    assign lsh = {32'd0, v} << cnt;
    assign rsh = {v, 32'd0} >> cnt;

    always_comb
    begin
        if (cnt == 6'd0)
        begin
            r = v;
            c = 1'b0;
            x = x_in;
        end
        else if (op == OP_LSL)
        begin
            r = lsh[31:0] & mask;
            c = lsh[wbit];
            x = c;
        end
        else
        begin
            r = rsh[63:32];
            c = rsh[31];
            x = c;
        end
    end

    always_comb
    begin
        if (size == SIZE_MEM)
        begin
            new_value      = dest_value;
            flags.x        = x_in;
            flags.n        = 1'b0;
            flags.z        = 1'b0;
            flags.v        = 1'b0;
            flags.c        = 1'b0;
            flags.mem_form = 1'b1;
        end
        else
        begin
            new_value      = (dest_value & ~mask) | r;
            flags.x        = x;
            flags.n        = r[msb];
            flags.z        = (r == 32'd0);
            flags.v        = 1'b0;
            flags.c        = c;
            flags.mem_form = 1'b0;
        end
    end

endmodule

>>> rtl/lsf_checker.sv
// Port-level checker for the logical shift block, with its bind.
module lsf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        flag_v,
    input logic        flag_n,
    input logic        flag_z,
    input logic        flag_c,
    input logic        not_register_form
);

    // Every accepted word produces a result on done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted word did not produce a result after two cycles");

    // No result appears without a matching accepted word before it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobe without a matching accepted word");

    // Overflow is never set by a logical shift.
    a_v_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !flag_v)
        else $error("overflow flag set on a logical shift");

    // The memory form reports no condition codes besides X.
    a_mem_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && not_register_form) |-> (!flag_n && !flag_z && !flag_c))
        else $error("memory form result carries condition codes");

    // A result cannot be both zero and negative.
    a_nz_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(flag_n && flag_z))
        else $error("negative and zero flags both set");

endmodule

bind logical_shift_with_flags lsf_checker u_lsf_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .flag_v            (flag_v),
    .flag_n            (flag_n),
    .flag_z            (flag_z),
    .flag_c            (flag_c),
    .not_register_form (not_register_form)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the register-form logical shift with condition codes.
module testbench;
    import lsf_pkg::*;

    // One command word as the block takes it.
    typedef struct {
        logic        op;
        logic [15:0] iw;
        logic [31:0] dest;
        logic [31:0] cnt_reg;
        logic        x;
    } shift_cmd_t;

    // One expected result: the register value and the condition codes.
    typedef struct {
        logic [31:0] value;
        flags_t      flags;
    } shift_res_t;

    // Cycles without any accepted command or result before the run is declared hung.
    // The longest correct quiet stretch is the reset period or the longest random
    // gap plus the pipeline latency, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 200;
    // Cycles to wait after the last result before the summary is printed.
    localparam int TAIL_CYCLES    = 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [15:0] instr_word;
    logic [31:0] dest_value;
    logic [31:0] count_reg_value;
    logic        x_in;
    logic        done;
    logic [31:0] new_value;
    logic        flag_x;
    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
    logic        flag_c;
    logic        not_register_form;

    // Expected results in the order their commands were taken.
    shift_res_t pending_results[$];

    int failures      = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int mem_form_sent = 0;
    int zero_cnt_sent = 0;
    int idle_cycles   = 0;
    // Upper bound for the random gap the sender draws before each word.
    int max_gap       = 10;

    logical_shift_with_flags uut (.*);

    always #5 clk = ~clk;

    // Predicted behavior of the shifter for one command. The operand is the low
    // byte, word or long of the destination; the bits above it pass through.
    // A register count is taken modulo 64, an immediate zero means eight.
    function automatic shift_res_t predict_shift(shift_cmd_t cmd);
        logic [1:0]  sz;
        logic [6:0]  count;
        int unsigned width;
        logic [31:0] mask;
        logic [63:0] operand;
        logic [31:0] shifted;
        logic        carry;
        logic        xout;
        shift_res_t  res;
        sz = cmd.iw[SIZE_HI:SIZE_LO];
        res.flags = '0;
        // The memory form is only flagged: value and X pass through, the
        // other codes are cleared.
        if (sz == SIZE_MEM)
        begin
            res.value          = cmd.dest;
            res.flags.x        = cmd.x;
            res.flags.mem_form = 1'b1;
            return res;
        end
        if (cmd.iw[IR_BIT])
        begin
            count = {1'b0, cmd.cnt_reg[5:0]};
        end
        else
        begin
            count = {4'b0, cmd.iw[CNT_HI:CNT_LO]};
            if (count == 0)
                count = {1'b0, IMM_ZERO_COUNT};
        end
        case (sz)
            SIZE_BYTE: width = 8;
            SIZE_WORD: width = 16;
            default:   width = 32;
        endcase
        mask    = (width == 32) ? 32'hFFFF_FFFF : ((32'h1 << width) - 32'h1);
        operand = {32'b0, cmd.dest & mask};
        if (count == 0)
        begin
            // No shift: C is cleared and X keeps its old value.
            shifted = operand[31:0];
            carry   = 1'b0;
            xout    = cmd.x;
        end
        else if (cmd.op == OP_LSL)
        begin
            // A count equal to the size still moves bit 0 out into C; beyond
            // the size everything is gone and C is zero.
            if (count <= width)
            begin
                carry   = operand[width - count];
                shifted = (operand[31:0] << count) & mask;
            end
            else
            begin
                carry   = 1'b0;
                shifted = '0;
            end
            xout = carry;
        end
        else
        begin
            // Right shifts read the carry from the 64-bit zero-extended
            // operand, so counts beyond the size give zero naturally.
            carry   = operand[count - 1];
            shifted = operand[31:0] >> count;
            xout    = carry;
        end
        res.value   = (cmd.dest & ~mask) | shifted;
        res.flags.x = xout;
        res.flags.n = shifted[width - 1];
        res.flags.z = (shifted == 0);
        res.flags.v = 1'b0;
        res.flags.c = carry;
        return res;
    endfunction

    // Instruction word with the given fields and random filler in the bits the
    // block should ignore.
    function automatic logic [15:0] make_iw(logic [2:0] cnt_field, logic [1:0] sz, logic ir);
        logic [15:0] w;
        w = 16'($urandom);
        w[CNT_HI:CNT_LO]   = cnt_field;
        w[SIZE_HI:SIZE_LO] = sz;
        w[IR_BIT]          = ir;
        return w;
    endfunction

    // Destination values biased toward patterns that hit the N and Z flags.
    function automatic logic [31:0] pick_dest();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Sends one word: idles for a random number of cycles, then holds start
    // until the word is taken. Start stays high afterward so that a following
    // word with no gap goes out back to back; whoever stops sending lowers it.
    task automatic send_word(shift_cmd_t cmd);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        op              <= cmd.op;
        instr_word      <= cmd.iw;
        dest_value      <= cmd.dest;
        count_reg_value <= cmd.cnt_reg;
        x_in            <= cmd.x;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(predict_shift(cmd));
        words_sent++;
        if (cmd.iw[SIZE_HI:SIZE_LO] == SIZE_MEM)
            mem_form_sent++;
        else if (cmd.iw[IR_BIT] && cmd.cnt_reg[5:0] == 6'd0)
            zero_cnt_sent++;
    endtask

    task automatic issue(logic o, logic [2:0] cnt_field, logic [1:0] sz, logic ir,
                         logic [31:0] dest, logic [31:0] cnt_reg, logic x);
        shift_cmd_t cmd;
        cmd.op      = o;
        cmd.iw      = make_iw(cnt_field, sz, ir);
        cmd.dest    = dest;
        cmd.cnt_reg = cnt_reg;
        cmd.x       = x;
        send_word(cmd);
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Corner cases: carry out of the top and bottom bits, an immediate zero
    // meaning eight, a zero register count keeping X, counts equal to and
    // beyond the operand size, count register upper bits ignored, the
    // memory form, and all-zero and all-one operands.
    task automatic test_directed_corners();
        issue(OP_LSL, 3'd1, SIZE_BYTE, 1'b0, 32'hFFFF_FF80, 32'h0, 1'b0);
        issue(OP_LSR, 3'd0, SIZE_BYTE, 1'b0, 32'h0000_00FF, 32'h0, 1'b0);
        issue(OP_LSL, 3'd0, SIZE_BYTE, 1'b0, 32'h1234_5601, 32'h0, 1'b1);
        issue(OP_LSL, 3'd5, SIZE_WORD, 1'b1, 32'hABCD_8000, 32'h0, 1'b1);
        issue(OP_LSR, 3'd2, SIZE_LONG, 1'b1, 32'h0000_0000, 32'hFFFF_FFC0, 1'b0);
        issue(OP_LSR, 3'd7, SIZE_BYTE, 1'b1, 32'hFFFF_FF00, 32'h0000_0040, 1'b1);
        issue(OP_LSL, 3'd3, SIZE_LONG, 1'b1, 32'h0000_0001, 32'd32, 1'b0);
        issue(OP_LSR, 3'd1, SIZE_LONG, 1'b1, 32'h8000_0000, 32'd32, 1'b0);
        issue(OP_LSR, 3'd4, SIZE_WORD, 1'b1, 32'h5555_8000, 32'd16, 1'b0);
        issue(OP_LSL, 3'd4, SIZE_WORD, 1'b1, 32'h0000_0001, 32'd16, 1'b1);
        issue(OP_LSL, 3'd6, SIZE_BYTE, 1'b1, 32'h0000_0001, 32'd8, 1'b0);
        issue(OP_LSL, 3'd6, SIZE_WORD, 1'b1, 32'hFFFF_FFFF, 32'd17, 1'b1);
        issue(OP_LSR, 3'd2, SIZE_BYTE, 1'b1, 32'hFFFF_FFFF, 32'd9, 1'b1);
        issue(OP_LSL, 3'd7, SIZE_LONG, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        issue(OP_LSR, 3'd7, SIZE_LONG, 1'b1, 32'hFFFF_FFFF, 32'd33, 1'b1);
        issue(OP_LSL, 3'd7, SIZE_LONG, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b0);
        issue(OP_LSR, 3'd1, SIZE_LONG, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b1);
        issue(OP_LSR, 3'd0, SIZE_LONG, 1'b0, 32'h0000_0080, 32'h0, 1'b0);
        issue(OP_LSR, 3'd3, SIZE_MEM,  1'b0, 32'hDEAD_BEEF, 32'h0, 1'b1);
        issue(OP_LSL, 3'd5, SIZE_MEM,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        issue(OP_LSL, 3'd0, SIZE_MEM,  1'b0, 32'h0000_0000, 32'h0, 1'b1);
    endtask

    // Every register count from 0 to 63 in both directions at every size, with
    // random upper bits in the count register.
    task automatic test_register_counts();
        for (int d = 0; d < 2; d++)
            for (int s = 0; s < 3; s++)
                for (int n = 0; n < 64; n++)
                    issue(d[0], 3'($urandom), 2'(s), 1'b1, pick_dest(),
                          ($urandom & 32'hFFFF_FFC0) | 32'(n), 1'($urandom));
    endtask

    // Every immediate count in both directions at every size.
    task automatic test_immediate_counts();
        for (int d = 0; d < 2; d++)
            for (int s = 0; s < 3; s++)
                for (int n = 0; n < 8; n++)
                    issue(d[0], 3'(n), 2'(s), 1'b0, pick_dest(), $urandom, 1'($urandom));
    endtask

    // Memory form with everything else random.
    task automatic test_memory_form();
        repeat (30)
            issue(1'($urandom), 3'($urandom), SIZE_MEM, 1'($urandom), $urandom, $urandom,
                  1'($urandom));
    endtask

    // Lets the pipeline drain completely, then sends a burst with no gaps so
    // that a word is taken on every cycle.
    task automatic test_drain_then_burst();
        wait_all_results();
        max_gap = 0;
        repeat (60)
            issue(1'($urandom), 3'($urandom), 2'($urandom_range(0, 2)), 1'($urandom),
                  pick_dest(), $urandom, 1'($urandom));
        max_gap = 10;
    endtask

    // Random words. The memory form is kept rare since it bypasses the shifter,
    // and stretches with random gaps are mixed at random with back-to-back stretches.
    task automatic test_random_mix();
        int          pick;
        logic [1:0]  sz;
        logic [31:0] cnt_reg;
        for (int i = 0; i < 950; i++)
        begin
            if (i % 50 == 0)
                max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
            pick = $urandom_range(0, 9);
            sz = (pick < 3) ? SIZE_BYTE : (pick < 6) ? SIZE_WORD : (pick < 9) ? SIZE_LONG
                                                                              : SIZE_MEM;
            // Small counts are biased in so that shifts inside the operand
            // size dominate over shifts that clear it.
            cnt_reg = $urandom;
            if ($urandom_range(0, 1) == 0)
                cnt_reg[5:0] = 6'($urandom_range(0, 33));
            issue(1'($urandom), 3'($urandom), sz, 1'($urandom), pick_dest(), cnt_reg,
                  1'($urandom));
        end
        max_gap = 10;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // Each result is on the ports for one cycle only, so it is checked at the
    // edge that ends that cycle, against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        shift_res_t want;
        if (done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: new_value %0h", new_value);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("new_value", want.value, new_value);
                check_field("flag_x", want.flags.x, flag_x);
                check_field("flag_n", want.flags.n, flag_n);
                check_field("flag_z", want.flags.z, flag_z);
                check_field("flag_v", want.flags.v, flag_v);
                check_field("flag_c", want.flags.c, flag_c);
                check_field("not_register_form", want.flags.mem_form, not_register_form);
                words_checked++;
            end
        end
    end

    // Ends a hung run: counts cycles in which neither a word nor a result moves.
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        op              = OP_LSR;
        instr_word      = '0;
        dest_value      = '0;
        count_reg_value = '0;
        x_in            = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_register_counts();
        test_immediate_counts();
        test_memory_form();
        test_drain_then_burst();
        test_random_mix();

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words, checked %0d results.", words_sent, words_checked);
        $display("Covered LSL and LSR at all sizes, every count, %0d zero counts, %0d %s",
                 zero_cnt_sent, mem_form_sent, "memory form.");
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> logical_shift_with_flags.f
rtl/lsf_pkg.sv
rtl/lsf_core.sv
rtl/logical_shift_with_flags.sv
rtl/lsf_checker.sv
verif/testbench.sv
